### sv/lspg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lspg_pkg;

	localparam int MAX_DIM = 4096;
	localparam int DIM_W = 13;
	localparam int PIX_W = 12;
	localparam int CFG_W = 13;
	localparam int CFG_IDX_W = 1;
	localparam int COLOR_W = 8;

	localparam int CHAR_COUNT = 10;
	localparam int GLYPH_ROWS = 7;
	localparam int GLYPH_COLS = 5;
	localparam int CHAR_PITCH = 6;

	localparam int PIPE_DEPTH = 7;

	localparam logic [DIM_W-1:0] RESET_WIDTH = 13'd1920;
	localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd1080;

	// Reciprocals scaled by 2^20; exact floors for every dimension up to 4096.
	localparam int RECIP_SHIFT = 20;
	localparam logic [14:0] RECIP60 = 15'd17477;
	localparam logic [16:0] RECIP12 = 17'd87382;
	localparam logic [18:0] RECIP3 = 19'd349526;

	localparam logic [COLOR_W-1:0] LIT_R = 8'd66;
	localparam logic [COLOR_W-1:0] LIT_G = 8'd184;
	localparam logic [COLOR_W-1:0] LIT_B = 8'd255;
	localparam logic [COLOR_W-1:0] BG_R = 8'd20;
	localparam logic [COLOR_W-1:0] BG_G = 8'd25;
	localparam logic [COLOR_W-1:0] BG_B = 8'd34;
	localparam logic [COLOR_W-1:0] ALPHA = 8'd255;

	typedef enum logic [0:0] {
		REG_WIDTH = 1'b0,
		REG_HEIGHT = 1'b1
	} cfg_reg_t;

	localparam logic [GLYPH_COLS-1:0] FONT [CHAR_COUNT][GLYPH_ROWS] = '{
		'{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1f},
		'{5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e},
		'{5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11},
		'{5'h1e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1e},
		'{5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1f},
		'{5'h11, 5'h19, 5'h19, 5'h15, 5'h13, 5'h13, 5'h11},
		'{5'h0e, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0f},
		'{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06},
		'{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06},
		'{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06}
	};

	typedef logic [GLYPH_ROWS:0][8:0] row_mul_t;
	typedef logic [CHAR_COUNT:0][11:0] char_mul_t;

	typedef struct packed {
		logic [12:0] w;
		logic [12:0] h;
		logic [6:0] wq60;
		logic [8:0] hq12;
		logic [10:0] wq3;
	} geo1_t;

	typedef struct packed {
		logic [12:0] w;
		logic [12:0] h;
		logic [10:0] wq3;
		logic [6:0] s;
	} geo2_t;

	typedef struct packed {
		logic [12:0] w;
		logic [12:0] h;
		logic [10:0] wq3;
		logic [6:0] s;
		logic [11:0] tw;
		logic [13:0] ox;
		logic [11:0] oy;
		logic [6:0] bh;
		row_mul_t ms;
		char_mul_t m6;
	} geo3_t;

	typedef struct packed {
		logic [12:0] w;
		logic [10:0] bw;
		logic [6:0] bh;
		logic [13:0] ya;
		logic [11:0] yb;
		row_mul_t ms;
		char_mul_t m6;
	} geo4_t;

	typedef struct packed {
		logic [11:0] bx;
		logic [12:0] bxe;
		logic [13:0] by;
		logic [13:0] bye;
		row_mul_t ms;
		char_mul_t m6;
	} geo5_t;

endpackage

`default_nettype wire

### sv/lspg_geom.sv
`timescale 1ns / 1ps
`default_nettype none

// Screen geometry, recomputed every cycle from the canvas size. Level n lines up
// with stage n of the pixel pipeline.
module lspg_geom (
	input wire logic clk,
	input wire logic [lspg_pkg::DIM_W-1:0] cfg_width,
	input wire logic [lspg_pkg::DIM_W-1:0] cfg_height,
	output lspg_pkg::geo1_t geo1,
	output lspg_pkg::geo3_t geo3,
	output lspg_pkg::geo4_t geo4,
	output lspg_pkg::geo5_t geo5
);

	lspg_pkg::geo1_t geo_s1, nxt1;
	lspg_pkg::geo2_t geo_s2, nxt2;
	lspg_pkg::geo3_t geo_s3, nxt3;
	lspg_pkg::geo4_t geo_s4, nxt4;
	lspg_pkg::geo5_t geo_s5, nxt5;

	always_comb begin
		logic [12:0] w_eff;
		logic [12:0] h_eff;
		logic [27:0] p60;
		logic [29:0] p12;
		logic [31:0] p3;
		if (cfg_width == '0) begin
			w_eff = 13'd1;
		end else if (cfg_width > 13'(lspg_pkg::MAX_DIM)) begin
			w_eff = 13'(lspg_pkg::MAX_DIM);
		end else begin
			w_eff = cfg_width;
		end
		if (cfg_height == '0) begin
			h_eff = 13'd1;
		end else if (cfg_height > 13'(lspg_pkg::MAX_DIM)) begin
			h_eff = 13'(lspg_pkg::MAX_DIM);
		end else begin
			h_eff = cfg_height;
		end
		p60 = 28'(w_eff) * 28'(lspg_pkg::RECIP60);
		p12 = 30'(h_eff) * 30'(lspg_pkg::RECIP12);
		p3 = 32'(w_eff) * 32'(lspg_pkg::RECIP3);
		nxt1.w = w_eff;
		nxt1.h = h_eff;
		nxt1.wq60 = p60[lspg_pkg::RECIP_SHIFT +: 7];
		nxt1.hq12 = p12[lspg_pkg::RECIP_SHIFT +: 9];
		nxt1.wq3 = p3[lspg_pkg::RECIP_SHIFT +: 11];
	end

	always_comb begin
		logic [6:0] smin;
		if (geo_s1.hq12 < {2'b00, geo_s1.wq60}) begin
			smin = geo_s1.hq12[6:0];
		end else begin
			smin = geo_s1.wq60;
		end
		nxt2.w = geo_s1.w;
		nxt2.h = geo_s1.h;
		nxt2.wq3 = geo_s1.wq3;
		nxt2.s = (smin == '0) ? 7'd1 : smin;
	end

	always_comb begin
		logic [12:0] s13;
		logic [12:0] tw13;
		logic [12:0] s7;
		logic [13:0] dox;
		logic [13:0] oxr;
		logic [13:0] ey;
		logic [12:0] fy;
		s13 = {6'd0, geo_s2.s};
		tw13 = (s13 << 6) - (s13 << 2) - s13;
		s7 = (s13 << 3) - s13;
		dox = {1'b0, geo_s2.w} - {1'b0, tw13};
		// An arithmetic shift rounds down, so a negative difference is raised by one first to halve toward zero.
		oxr = dox + {13'd0, dox[13]};
		ey = {1'b0, geo_s2.h} - {1'b0, s7};
		fy = {1'b0, ey[12:1]} - s13;
		nxt3.w = geo_s2.w;
		nxt3.h = geo_s2.h;
		nxt3.wq3 = geo_s2.wq3;
		nxt3.s = geo_s2.s;
		nxt3.tw = tw13[11:0];
		nxt3.ox = {oxr[13], oxr[13:1]};
		if (ey[13] || fy[12]) begin
			nxt3.oy = '0;
		end else begin
			nxt3.oy = fy[11:0];
		end
		nxt3.bh = (geo_s2.s < 7'd2) ? 7'd2 : geo_s2.s;
		for (int k = 0; k <= lspg_pkg::GLYPH_ROWS; k++) begin
			nxt3.ms[k] = 9'(k * int'(geo_s2.s));
		end
		for (int k = 0; k <= lspg_pkg::CHAR_COUNT; k++) begin
			nxt3.m6[k] = 12'(lspg_pkg::CHAR_PITCH * k * int'(geo_s2.s));
		end
	end

	always_comb begin
		logic [10:0] bmin;
		logic [11:0] s12;
		logic [11:0] s9;
		if ({1'b0, geo_s3.wq3} < geo_s3.tw) begin
			bmin = geo_s3.wq3;
		end else begin
			bmin = geo_s3.tw[10:0];
		end
		s12 = {5'd0, geo_s3.s};
		s9 = (s12 << 3) + s12;
		nxt4.w = geo_s3.w;
		nxt4.bw = (bmin == '0) ? 11'd1 : bmin;
		nxt4.bh = geo_s3.bh;
		nxt4.ya = {1'b0, geo_s3.h} - {7'd0, geo_s3.bh};
		nxt4.yb = geo_s3.oy + s9;
		nxt4.ms = geo_s3.ms;
		nxt4.m6 = geo_s3.m6;
	end

	always_comb begin
		logic [12:0] bxd;
		logic [13:0] by;
		bxd = geo_s4.w - {2'b00, geo_s4.bw};
		if ($signed(geo_s4.ya) < $signed({2'b00, geo_s4.yb})) begin
			by = geo_s4.ya;
		end else begin
			by = {2'b00, geo_s4.yb};
		end
		nxt5.bx = bxd[12:1];
		nxt5.bxe = {1'b0, bxd[12:1]} + {2'b00, geo_s4.bw};
		nxt5.by = by;
		nxt5.bye = by + {7'd0, geo_s4.bh};
		nxt5.ms = geo_s4.ms;
		nxt5.m6 = geo_s4.m6;
	end

	always_ff @(posedge clk) begin
		geo_s1 <= nxt1;
		geo_s2 <= nxt2;
		geo_s3 <= nxt3;
		geo_s4 <= nxt4;
		geo_s5 <= nxt5;
	end

	assign geo1 = geo_s1;
	assign geo3 = geo_s3;
	assign geo4 = geo_s4;
	assign geo5 = geo_s5;

endmodule

`default_nettype wire

### sv/lspg_pix.sv
`timescale 1ns / 1ps
`default_nettype none

module lspg_pix (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic accept,
	input wire logic [lspg_pkg::PIX_W-1:0] pixel_x,
	input wire logic [lspg_pkg::PIX_W-1:0] pixel_y,
	input wire lspg_pkg::geo1_t geo1,
	input wire lspg_pkg::geo3_t geo3,
	input wire lspg_pkg::geo4_t geo4,
	input wire lspg_pkg::geo5_t geo5,
	output logic done,
	output logic [lspg_pkg::COLOR_W-1:0] red,
	output logic [lspg_pkg::COLOR_W-1:0] green,
	output logic [lspg_pkg::COLOR_W-1:0] blue,
	output logic [lspg_pkg::COLOR_W-1:0] alpha,
	output logic lit
);

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic [11:0] x_s1, x_s2, x_s3, x_s4, x_s5;
	logic [11:0] y_s1, y_s2, y_s3, y_s4, y_s5;
	logic inc_s2, inc_s3, inc_s4, inc_s5, inc_s6;
	logic [13:0] dx_s4, dy_s4;
	logic [12:0] dx_s5;
	logic inbox_s5, inbox_s6;
	logic [3:0] ci_s5, ci_s6;
	logic [2:0] row_s5, row_s6;
	logic [2:0] col_s6;
	logic bar_s6;
	logic lit_s7;
	logic [lspg_pkg::COLOR_W-1:0] red_s7, green_s7, blue_s7, alpha_s7;

	logic inbox_d5;
	logic [3:0] ci_d5;
	logic [2:0] row_d5;
	logic [2:0] col_d6;
	logic bar_d6;
	logic lit_d7;

	always_comb begin
		inbox_d5 = !dx_s4[13] && !dy_s4[13]
			&& (dx_s4[12:0] < {1'b0, geo4.m6[lspg_pkg::CHAR_COUNT]})
			&& (dy_s4[12:0] < {4'd0, geo4.ms[lspg_pkg::GLYPH_ROWS]});
		ci_d5 = '0;
		for (int k = 1; k < lspg_pkg::CHAR_COUNT; k++) begin
			if (dx_s4[12:0] >= {1'b0, geo4.m6[k]}) begin
				ci_d5 = 4'(k);
			end
		end
		row_d5 = '0;
		for (int k = 1; k < lspg_pkg::GLYPH_ROWS; k++) begin
			if (dy_s4[12:0] >= {4'd0, geo4.ms[k]}) begin
				row_d5 = 3'(k);
			end
		end
	end

	always_comb begin
		logic [12:0] rem;
		rem = dx_s5 - {1'b0, geo5.m6[ci_s5]};
		col_d6 = '0;
		for (int k = 1; k <= lspg_pkg::GLYPH_COLS; k++) begin
			if (rem >= {4'd0, geo5.ms[k]}) begin
				col_d6 = 3'(k);
			end
		end
		bar_d6 = (x_s5 >= geo5.bx) && ({1'b0, x_s5} < geo5.bxe)
			&& ($signed({2'b00, y_s5}) >= $signed(geo5.by))
			&& ($signed({2'b00, y_s5}) < $signed(geo5.bye));
	end

	always_comb begin
		logic [lspg_pkg::GLYPH_COLS-1:0] glyph;
		logic text_bit;
		glyph = lspg_pkg::FONT[ci_s6][row_s6];
		text_bit = 1'b0;
		if (inbox_s6 && col_s6 < 3'(lspg_pkg::GLYPH_COLS)) begin
			text_bit = glyph[3'(lspg_pkg::GLYPH_COLS - 1) - col_s6];
		end
		lit_d7 = inc_s6 && (text_bit || bar_s6);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= pixel_x;
		y_s1 <= pixel_y;

		x_s2 <= x_s1;
		y_s2 <= y_s1;
		inc_s2 <= ({1'b0, x_s1} < geo1.w) && ({1'b0, y_s1} < geo1.h);

		x_s3 <= x_s2;
		y_s3 <= y_s2;
		inc_s3 <= inc_s2;

		x_s4 <= x_s3;
		y_s4 <= y_s3;
		inc_s4 <= inc_s3;
		dx_s4 <= {2'b00, x_s3} - geo3.ox;
		dy_s4 <= {2'b00, y_s3} - {2'b00, geo3.oy};

		x_s5 <= x_s4;
		y_s5 <= y_s4;
		inc_s5 <= inc_s4;
		dx_s5 <= dx_s4[12:0];
		inbox_s5 <= inbox_d5;
		ci_s5 <= ci_d5;
		row_s5 <= row_d5;

		inc_s6 <= inc_s5;
		inbox_s6 <= inbox_s5;
		ci_s6 <= ci_s5;
		row_s6 <= row_s5;
		col_s6 <= col_d6;
		bar_s6 <= bar_d6;

		lit_s7 <= lit_d7;
		red_s7 <= lit_d7 ? lspg_pkg::LIT_R : lspg_pkg::BG_R;
		green_s7 <= lit_d7 ? lspg_pkg::LIT_G : lspg_pkg::BG_G;
		blue_s7 <= lit_d7 ? lspg_pkg::LIT_B : lspg_pkg::BG_B;
		alpha_s7 <= lspg_pkg::ALPHA;
	end

	assign done = valid_s7;
	assign red = red_s7;
	assign green = green_s7;
	assign blue = blue_s7;
	assign alpha = alpha_s7;
	assign lit = lit_s7;

`ifndef SYNTHESIS
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && inbox_s5 |-> ci_s5 < 4'(lspg_pkg::CHAR_COUNT))
		else $error("character index beyond the text");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 && inbox_s6 |-> row_s6 < 3'(lspg_pkg::GLYPH_ROWS))
		else $error("glyph row beyond the font");

	a_color_match: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (lit ? (red == lspg_pkg::LIT_R && blue == lspg_pkg::LIT_B)
			: (red == lspg_pkg::BG_R && blue == lspg_pkg::BG_B)))
		else $error("colour does not match lit flag");
`endif

endmodule

`default_nettype wire

### sv/loading_splash_pixel_generator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake             Payload
// input     start / busy          pixel_x, pixel_y
// result    done                  red, green, blue, alpha, lit
// config    cfg_we                cfg_index, cfg_data
//
// A word is taken in every clock cycle; busy is always low.
// A word accepted at an edge passes through seven register stages, valid_s1 to
// valid_s7, and is on the result ports for exactly one cycle.
// Reset sets the canvas to 1920 by 1080 and clears every valid bit.
// The receiver cannot stall the pipeline, so nothing ever waits inside it.
module loading_splash_pixel_generator #(
	parameter int CFG_IDX_W = lspg_pkg::CFG_IDX_W
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [lspg_pkg::PIX_W-1:0] pixel_x,
	input wire logic [lspg_pkg::PIX_W-1:0] pixel_y,
	output logic done,
	output logic [lspg_pkg::COLOR_W-1:0] red,
	output logic [lspg_pkg::COLOR_W-1:0] green,
	output logic [lspg_pkg::COLOR_W-1:0] blue,
	output logic [lspg_pkg::COLOR_W-1:0] alpha,
	output logic lit,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [lspg_pkg::CFG_W-1:0] cfg_data
);

	logic [lspg_pkg::DIM_W-1:0] width_q;
	logic [lspg_pkg::DIM_W-1:0] height_q;
	logic accept;

	lspg_pkg::geo1_t geo1;
	lspg_pkg::geo3_t geo3;
	lspg_pkg::geo4_t geo4;
	lspg_pkg::geo5_t geo5;

	assign busy = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= lspg_pkg::RESET_WIDTH;
			height_q <= lspg_pkg::RESET_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IDX_W'(lspg_pkg::REG_WIDTH): begin
					width_q <= cfg_data;
				end
				CFG_IDX_W'(lspg_pkg::REG_HEIGHT): begin
					height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	lspg_geom u_geom (
		.clk(clk),
		.cfg_width(width_q),
		.cfg_height(height_q),
		.geo1(geo1),
		.geo3(geo3),
		.geo4(geo4),
		.geo5(geo5)
	);

	lspg_pix u_pix (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.geo1(geo1),
		.geo3(geo3),
		.geo4(geo4),
		.geo5(geo5),
		.done(done),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha),
		.lit(lit)
	);

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##7 done)
		else $error("accepted word produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 7))
		else $error("result without an accepted word");
`endif

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int IDX_W = 2;
	localparam int CLK_HALF = 10;
	localparam int LIMIT = 400000;
	localparam int DRAIN_CYCLES = 12;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 100;
	localparam int RANDOM_DIM = -1;
	localparam int DIM_CAP = 4096;
	localparam int PIX_MAX = 4095;

	localparam logic [IDX_W-1:0] IDX_CANVAS_W = IDX_W'(lspg_pkg::REG_WIDTH);
	localparam logic [IDX_W-1:0] IDX_CANVAS_H = IDX_W'(lspg_pkg::REG_HEIGHT);
	localparam logic [IDX_W-1:0] IDX_UNUSED_A = 2'd2;
	localparam logic [IDX_W-1:0] IDX_UNUSED_B = 2'd3;

	localparam logic [7:0] ON_RED = 8'd66;
	localparam logic [7:0] ON_GREEN = 8'd184;
	localparam logic [7:0] ON_BLUE = 8'd255;
	localparam logic [7:0] OFF_RED = 8'd20;
	localparam logic [7:0] OFF_GREEN = 8'd25;
	localparam logic [7:0] OFF_BLUE = 8'd34;
	localparam logic [7:0] OPAQUE = 8'd255;

	// Rows of "LOADING..." from the top, most significant bit is the leftmost dot.
	localparam logic [0:69][4:0] GLYPHS = {
		5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1f,
		5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e,
		5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11,
		5'h1e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1e,
		5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1f,
		5'h11, 5'h19, 5'h19, 5'h15, 5'h13, 5'h13, 5'h11,
		5'h0e, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0f,
		5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06,
		5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06,
		5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06
	};

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic lit;
	} splash_pixel_t;

	class splash_scoreboard;
		logic [12:0] width_reg;
		logic [12:0] height_reg;
		splash_pixel_t expected_q[$];
		int errors;

		function new();
			width_reg = 13'd1920;
			height_reg = 13'd1080;
			errors = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [12:0] data);
			if (idx == IDX_CANVAS_W) begin
				width_reg = data;
			end else if (idx == IDX_CANVAS_H) begin
				height_reg = data;
			end
		endfunction

		function int clamp_dim(logic [12:0] v);
			if (v == 0) begin
				return 1;
			end
			if (v > DIM_CAP) begin
				return DIM_CAP;
			end
			return int'(v);
		endfunction

		function void get_layout(output int w, output int h, output int s, output int ox,
				output int oy, output int bw, output int bh, output int bx, output int by);
			int tw;
			w = clamp_dim(width_reg);
			h = clamp_dim(height_reg);
			s = (w / 60 < h / 12) ? w / 60 : h / 12;
			if (s < 1) begin
				s = 1;
			end
			tw = 59 * s;
			ox = (w - tw) / 2;
			oy = (h - 7 * s) / 2 - s;
			if (oy < 0) begin
				oy = 0;
			end
			bw = (w / 3 < tw) ? w / 3 : tw;
			if (bw < 1) begin
				bw = 1;
			end
			bh = (s > 2) ? s : 2;
			bx = (w - bw) / 2;
			by = (h - bh < oy + 9 * s) ? h - bh : oy + 9 * s;
		endfunction

		function bit pixel_on(int x, int y);
			int w, h, s, ox, oy, bw, bh, bx, by;
			int dx, dy, ci, col, row;
			logic [4:0] dots;
			get_layout(w, h, s, ox, oy, bw, bh, bx, by);
			if (x >= w || y >= h) begin
				return 1'b0;
			end
			dx = x - ox;
			dy = y - oy;
			if (dx >= 0 && dy >= 0 && dx < 60 * s && dy < 7 * s) begin
				ci = dx / (6 * s);
				col = (dx % (6 * s)) / s;
				row = dy / s;
				if (col < 5) begin
					dots = GLYPHS[ci * 7 + row];
					if (dots[4 - col]) begin
						return 1'b1;
					end
				end
			end
			return x >= bx && x < bx + bw && y >= by && y < by + bh;
		endfunction

		function void note_pixel(logic [11:0] x, logic [11:0] y);
			splash_pixel_t p;
			if (pixel_on(int'(x), int'(y))) begin
				p = '{ON_RED, ON_GREEN, ON_BLUE, OPAQUE, 1'b1};
			end else begin
				p = '{OFF_RED, OFF_GREEN, OFF_BLUE, OPAQUE, 1'b0};
			end
			expected_q.push_back(p);
		endfunction

		function void compare_field(string name, int exp_v, int act_v);
			if (exp_v != act_v) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_pixel(splash_pixel_t act);
			splash_pixel_t exp_p;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %0d/%0d/%0d/%0d lit %0d",
					$time, act.red, act.green, act.blue, act.alpha, act.lit);
				errors++;
				return;
			end
			exp_p = expected_q.pop_front();
			compare_field("red", exp_p.red, act.red);
			compare_field("green", exp_p.green, act.green);
			compare_field("blue", exp_p.blue, act.blue);
			compare_field("alpha", exp_p.alpha, act.alpha);
			compare_field("lit", exp_p.lit, act.lit);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [lspg_pkg::PIX_W-1:0] pixel_x;
	logic [lspg_pkg::PIX_W-1:0] pixel_y;
	logic done;
	logic [lspg_pkg::COLOR_W-1:0] red;
	logic [lspg_pkg::COLOR_W-1:0] green;
	logic [lspg_pkg::COLOR_W-1:0] blue;
	logic [lspg_pkg::COLOR_W-1:0] alpha;
	logic lit;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [lspg_pkg::CFG_W-1:0] cfg_data;

	splash_scoreboard sb;
	int idle_pct;
	int cycle_count;

	loading_splash_pixel_generator #(
		.CFG_IDX_W(IDX_W)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.done(done),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha),
		.lit(lit),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	initial cycle_count = 0;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				sb.write_reg(cfg_index, cfg_data);
			end
			if (start && !busy) begin
				sb.note_pixel(pixel_x, pixel_y);
			end
			if (done) begin
				sb.check_pixel({red, green, blue, alpha, lit});
			end
		end
	end

	function automatic logic [11:0] rand_span(int lo, int hi);
		if (lo < 0) begin
			lo = 0;
		end
		if (lo > PIX_MAX) begin
			lo = PIX_MAX;
		end
		if (hi > PIX_MAX) begin
			hi = PIX_MAX;
		end
		if (hi < lo) begin
			hi = lo;
		end
		return 12'($urandom_range(hi, lo));
	endfunction

	task automatic send_pixel(input logic [11:0] x, input logic [11:0] y);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		pixel_x <= x;
		pixel_y <= y;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic configure(input logic [12:0] w_val, input logic [12:0] h_val);
		cfg_we <= 1'b1;
		cfg_index <= IDX_CANVAS_W;
		cfg_data <= w_val;
		@(negedge clk);
		cfg_index <= IDX_CANVAS_H;
		cfg_data <= h_val;
		@(negedge clk);
		// Writes to unused indexes must leave the canvas alone.
		cfg_index <= $urandom_range(1) ? IDX_UNUSED_A : IDX_UNUSED_B;
		cfg_data <= 13'($urandom);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_phase(input int n_items);
		int w, h, s, ox, oy, bw, bh, bx, by;
		int pick;
		logic [11:0] x;
		logic [11:0] y;
		sb.get_layout(w, h, s, ox, oy, bw, bh, bx, by);
		for (int i = 0; i < n_items; i++) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				x = rand_span(ox - 2, ox + 60 * s + 1);
				y = rand_span(oy - 2, oy + 7 * s + 1);
			end else if (pick < 65) begin
				x = rand_span(bx - 2, bx + bw + 1);
				y = rand_span(by - 2, by + bh + 1);
			end else if (pick < 85) begin
				x = 12'($urandom_range(w - 1));
				y = 12'($urandom_range(h - 1));
			end else begin
				x = 12'($urandom);
				y = 12'($urandom);
			end
			send_pixel(x, y);
		end
	endtask

	initial begin
		int dir_x[24];
		int dir_y[24];
		int phase_w[PHASES];
		int phase_h[PHASES];
		int idle_modes[3];
		logic [12:0] w_val;
		logic [12:0] h_val;

		dir_x = '{0, 4095, 1919, 1920, 500, 16, 15, 144, 16, 144, 176, 208,
			240, 1392, 1360, 640, 1279, 639, 1280, 700, 700, 4095, 0, 2048};
		dir_y = '{0, 4095, 1079, 500, 1080, 396, 396, 396, 588, 588, 588, 396,
			396, 556, 556, 684, 715, 684, 700, 683, 716, 0, 4095, 2048};
		phase_w = '{1920, 0, 8191, 4096, 60, 59, 4097, 120, 640, RANDOM_DIM, 200, RANDOM_DIM};
		phase_h = '{1080, 0, 8191, 4096, 12, 11, 24, 4096, 480, RANDOM_DIM, 13, RANDOM_DIM};
		idle_modes = '{0, 65, 37};

		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		pixel_x = '0;
		pixel_y = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_pct = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < 24; i++) begin
			send_pixel(12'(dir_x[i]), 12'(dir_y[i]));
		end
		drain();

		for (int p = 0; p < PHASES; p++) begin
			if (p != 0) begin
				w_val = (phase_w[p] == RANDOM_DIM) ? 13'($urandom) : 13'(phase_w[p]);
				h_val = (phase_h[p] == RANDOM_DIM) ? 13'($urandom) : 13'(phase_h[p]);
				configure(w_val, h_val);
			end
			idle_pct = idle_modes[p % 3];
			run_phase(PHASE_ITEMS);
			drain();
		end

		if (sb.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
